[hdl/lprm_pkg.sv]
// Shared types and constants for the LCMS pair relative momentum block.
// Holds the request and response word layouts, status codes and width helpers.
// No dependencies.
`default_nettype none

package lprm_pkg;

   // Default momentum word width and the range the datapath supports.
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int MOM_MIN_BITS      = 16;
   localparam int MOM_MAX_BITS      = 32;

   // Extra fraction bits carried through the square roots and divisions.
   localparam int GUARD_BITS = 30;

   // Mode register codes. Any nonzero mode mirrors the transverse plane
   // and the upper mode bit also mirrors the beam axis.
   localparam logic [1:0] MODE_NORMAL     = 2'd0;
   localparam int         MODE_Z_MIRROR_BIT = 1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FLAT      = 2'd1,
      STATUS_SPACELIKE = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] p1_x;
      logic signed [31:0] p1_y;
      logic signed [31:0] p1_z;
      logic        [30:0] p1_energy;
      logic signed [31:0] p2_x;
      logic signed [31:0] p2_y;
      logic signed [31:0] p2_z;
      logic        [30:0] p2_energy;
   } req_type;

   typedef struct packed {
      logic signed [31:0] q_out;
      logic signed [31:0] q_side;
      logic signed [31:0] q_long;
      logic        [30:0] q_invariant;
      status_type         status;
   } rsp_type;

   // Momentum width actually used by the datapath.
   function automatic int clamp_mom_bits(input int bits);
      int r;
      r = bits;
      if (bits < MOM_MIN_BITS) begin
         r = MOM_MIN_BITS;
      end else if (bits > MOM_MAX_BITS) begin
         r = MOM_MAX_BITS;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/lprm_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, several lanes.
// Carries a side word alongside the lanes. No package dependencies.
`default_nettype none

module lprm_sqrt_pipe #(
   parameter int ROOT_BITS = 63,
   parameter int LANES     = 3,
   parameter int SIDE_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire logic                                  in_valid,
   input  wire logic [LANES-1:0][2*ROOT_BITS-1:0]     in_radicand,
   input  wire logic [SIDE_BITS-1:0]                  in_side,
   output logic                                       out_valid,
   output logic [LANES-1:0][ROOT_BITS-1:0]            out_root,
   output logic [SIDE_BITS-1:0]                       out_side
);

   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 1;
   localparam int CMP_BITS = ROOT_BITS + 3;

   logic [ROOT_BITS-1:0] valid_ff, valid_in;

   logic [LANES-1:0][RAD_BITS-1:0]  rad_ff  [ROOT_BITS];
   logic [LANES-1:0][RAD_BITS-1:0]  rad_in  [ROOT_BITS];
   logic [LANES-1:0][RAD_BITS-1:0]  rad_src [ROOT_BITS];
   logic [LANES-1:0][REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [LANES-1:0][REM_BITS-1:0]  rem_in  [ROOT_BITS];
   logic [LANES-1:0][REM_BITS-1:0]  rem_src [ROOT_BITS];
   logic [LANES-1:0][ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   logic [LANES-1:0][ROOT_BITS-1:0] root_in  [ROOT_BITS];
   logic [LANES-1:0][ROOT_BITS-1:0] root_src [ROOT_BITS];
   logic [SIDE_BITS-1:0]            side_ff  [ROOT_BITS];
   logic [SIDE_BITS-1:0]            side_in  [ROOT_BITS];

   always_comb begin
      logic [CMP_BITS-1:0] rem_sh;
      logic [CMP_BITS-1:0] trial;
      logic [CMP_BITS-1:0] diff;
      logic                ge;
      valid_in    = {valid_ff[ROOT_BITS-2:0], in_valid};
      rad_src[0]  = in_radicand;
      rem_src[0]  = '0;
      root_src[0] = '0;
      side_in[0]  = in_side;
      for (int s = 1; s < ROOT_BITS; s++) begin
         rad_src[s]  = rad_ff[s-1];
         rem_src[s]  = rem_ff[s-1];
         root_src[s] = root_ff[s-1];
         side_in[s]  = side_ff[s-1];
      end
      for (int s = 0; s < ROOT_BITS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            // Bring down the next two radicand bits and try root*4+1.
            rem_sh = {rem_src[s][l], rad_src[s][l][RAD_BITS-1 -: 2]};
            trial  = {1'b0, root_src[s][l], 2'b01};
            diff   = rem_sh - trial;
            ge     = (rem_sh >= trial);
            rem_in[s][l]  = ge ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
            root_in[s][l] = {root_src[s][l][ROOT_BITS-2:0], ge};
            rad_in[s][l]  = {rad_src[s][l][RAD_BITS-3:0], 2'b00};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < ROOT_BITS; s++) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

`default_nettype wire

[hdl/lprm_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Carries a side word alongside the lanes. No package dependencies.
`default_nettype none

module lprm_div_pipe #(
   parameter int DEN_BITS  = 63,
   parameter int QUO_BITS  = 32,
   parameter int LANES     = 3,
   parameter int SIDE_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              in_valid,
   input  wire logic [LANES-1:0][DEN_BITS-1:0]    in_rem,
   input  wire logic [LANES-1:0][QUO_BITS-1:0]    in_low,
   input  wire logic [LANES-1:0][DEN_BITS-1:0]    in_den,
   input  wire logic [SIDE_BITS-1:0]              in_side,
   output logic                                   out_valid,
   output logic [LANES-1:0][QUO_BITS-1:0]         out_quot,
   output logic [SIDE_BITS-1:0]                   out_side
);

   logic [QUO_BITS-1:0] valid_ff, valid_in;

   logic [LANES-1:0][DEN_BITS-1:0] rem_ff  [QUO_BITS];
   logic [LANES-1:0][DEN_BITS-1:0] rem_in  [QUO_BITS];
   logic [LANES-1:0][DEN_BITS-1:0] rem_src [QUO_BITS];
   logic [LANES-1:0][QUO_BITS-1:0] low_ff  [QUO_BITS];
   logic [LANES-1:0][QUO_BITS-1:0] low_in  [QUO_BITS];
   logic [LANES-1:0][QUO_BITS-1:0] low_src [QUO_BITS];
   logic [LANES-1:0][DEN_BITS-1:0] den_ff  [QUO_BITS];
   logic [LANES-1:0][DEN_BITS-1:0] den_in  [QUO_BITS];
   logic [SIDE_BITS-1:0]           side_ff [QUO_BITS];
   logic [SIDE_BITS-1:0]           side_in [QUO_BITS];

   always_comb begin
      logic [DEN_BITS:0] rem_sh;
      logic [DEN_BITS:0] diff;
      logic              ge;
      valid_in   = {valid_ff[QUO_BITS-2:0], in_valid};
      rem_src[0] = in_rem;
      low_src[0] = in_low;
      den_in[0]  = in_den;
      side_in[0] = in_side;
      for (int s = 1; s < QUO_BITS; s++) begin
         rem_src[s] = rem_ff[s-1];
         low_src[s] = low_ff[s-1];
         den_in[s]  = den_ff[s-1];
         side_in[s] = side_ff[s-1];
      end
      for (int s = 0; s < QUO_BITS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            // The low word shifts dividend bits out and quotient bits in.
            rem_sh = {rem_src[s][l], low_src[s][l][QUO_BITS-1]};
            diff   = rem_sh - {1'b0, den_in[s][l]};
            ge     = (rem_sh >= {1'b0, den_in[s][l]});
            rem_in[s][l] = ge ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
            low_in[s][l] = {low_src[s][l][QUO_BITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < QUO_BITS; s++) begin
            rem_ff[s]  <= rem_in[s];
            low_ff[s]  <= low_in[s];
            den_ff[s]  <= den_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_quot  = low_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];

endmodule

`default_nettype wire

[hdl/lcms_pair_relative_momentum.sv]
// Top level of the LCMS pair relative momentum pipeline.
// Depends on lprm_pkg, lprm_sqrt_pipe and lprm_div_pipe.
//
// Usage: each request word carries two four-momenta in signed fixed point
// with 16 fraction bits. The block returns one response word per request
// with q_out, q_side, q_long, the invariant magnitude and a status code.
// The request channel and the response channel both use valid and stall;
// a word moves at a clock edge where valid is high and stall is low.
// The csr port writes the two-bit pair mode; the user must write it only
// while the pipeline is empty, as the block itself does not enforce this.
// Throughput is one pair per clock while the receiver does not stall. A
// pair passes, in order, through the registers of sums, products and sums
// of products, the bit-serial square root stages, a preparation stage,
// the divider stages and the output register.
// Reset clears every valid bit and sets the pair mode to normal; no
// clearing pass is needed. When the receiver stalls while a response is
// held, the whole pipeline freezes and the request channel stalls too, so
// nothing is lost or repeated.
`default_nettype none

module lcms_pair_relative_momentum #(
   parameter int WORD_BITS = lprm_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lprm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lprm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_write_data
);

   import lprm_pkg::*;

   // Widths of the datapath, all derived from the momentum width.
   localparam int MB     = clamp_mom_bits(WORD_BITS);  // momentum bits
   localparam int SW     = MB + 1;                     // sums and differences
   localparam int PW     = 2 * MB + 2;                 // single products
   localparam int NW     = 2 * MB + 3;                 // sums of products
   localparam int NB     = 2 * MB + 2;                 // numerator magnitudes
   localparam int RB     = MB + GUARD_BITS + 1;        // root and divisor bits
   localparam int XB     = NB + GUARD_BITS;            // scaled numerator
   localparam int HB     = XB - MB;                    // dividend head
   localparam int SIDE_A = 3 * NW + 2;
   localparam int SIDE_B = MB + 8;
   localparam int LANES  = 3;

   // The pipeline moves as one unit whenever the output register is free.
   logic rsp_valid_ff;
   logic advance;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // ---------------------------------------------------------------------
   // Mode register.
   logic [1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: sign extend, mirror particle two, form pair sums and
   // differences.
   logic                 s1_valid_ff;
   logic signed [SW-1:0] px_ff, py_ff, pz_ff, e_ff, dx_ff, dy_ff, dz_ff, de_ff;
   logic signed [SW-1:0] px_in, py_in, pz_in, e_in, dx_in, dy_in, dz_in, de_in;

   always_comb begin
      logic signed [SW-1:0] ax, ay, az, ae, bx, by, bz, be;
      logic                 tmir, zmir;
      tmir = (mode_ff != MODE_NORMAL);
      zmir = mode_ff[MODE_Z_MIRROR_BIT];
      ax = {req_data.p1_x[MB-1], req_data.p1_x[MB-1:0]};
      ay = {req_data.p1_y[MB-1], req_data.p1_y[MB-1:0]};
      az = {req_data.p1_z[MB-1], req_data.p1_z[MB-1:0]};
      ae = {2'b00, req_data.p1_energy[MB-2:0]};
      bx = {req_data.p2_x[MB-1], req_data.p2_x[MB-1:0]};
      by = {req_data.p2_y[MB-1], req_data.p2_y[MB-1:0]};
      bz = {req_data.p2_z[MB-1], req_data.p2_z[MB-1:0]};
      be = {2'b00, req_data.p2_energy[MB-2:0]};
      if (tmir) begin
         bx = -bx;
         by = -by;
      end
      if (zmir) begin
         bz = -bz;
      end
      px_in = ax + bx;
      py_in = ay + by;
      pz_in = az + bz;
      e_in  = ae + be;
      dx_in = ax - bx;
      dy_in = ay - by;
      dz_in = az - bz;
      de_in = ae - be;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         e_ff  <= e_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         de_ff <= de_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: all products, each one multiplier of the sum and difference width.
   logic                 s2_valid_ff;
   logic signed [PW-1:0] pxx_ff, pyy_ff, dxpx_ff, dypy_ff, dypx_ff, dxpy_ff;
   logic signed [PW-1:0] ee_ff, pzz_ff, edz_ff, pzde_ff;
   logic signed [PW-1:0] dxx_ff, dyy_ff, dzz_ff, dee_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pxx_ff  <= PW'(px_ff) * PW'(px_ff);
         pyy_ff  <= PW'(py_ff) * PW'(py_ff);
         dxpx_ff <= PW'(dx_ff) * PW'(px_ff);
         dypy_ff <= PW'(dy_ff) * PW'(py_ff);
         dypx_ff <= PW'(dy_ff) * PW'(px_ff);
         dxpy_ff <= PW'(dx_ff) * PW'(py_ff);
         ee_ff   <= PW'(e_ff) * PW'(e_ff);
         pzz_ff  <= PW'(pz_ff) * PW'(pz_ff);
         edz_ff  <= PW'(e_ff) * PW'(dz_ff);
         pzde_ff <= PW'(pz_ff) * PW'(de_ff);
         dxx_ff  <= PW'(dx_ff) * PW'(dx_ff);
         dyy_ff  <= PW'(dy_ff) * PW'(dy_ff);
         dzz_ff  <= PW'(dz_ff) * PW'(dz_ff);
         dee_ff  <= PW'(de_ff) * PW'(de_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: squared pair pt, transverse mass squared, the three
   // numerators and the invariant q squared.
   logic                 s3_valid_ff;
   logic signed [NW-1:0] s_ff, m_ff, nout_ff, nside_ff, nlong_ff, r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff     <= NW'(pxx_ff) + NW'(pyy_ff);
         m_ff     <= NW'(ee_ff) - NW'(pzz_ff);
         nout_ff  <= NW'(dxpx_ff) + NW'(dypy_ff);
         nside_ff <= NW'(dypx_ff) - NW'(dxpy_ff);
         nlong_ff <= NW'(edz_ff) - NW'(pzde_ff);
         r_ff     <= (NW'(dxx_ff) + NW'(dyy_ff)) + (NW'(dzz_ff) - NW'(dee_ff));
      end
   end

   // ---------------------------------------------------------------------
   // Square roots: pair pt and transverse mass scaled by the guard bits,
   // and the invariant magnitude. Degenerate lanes run anyway and their
   // results are masked at the end.
   logic                           flat_a, spacelike_a;
   logic signed [NW-1:0]           r_mag;
   logic [LANES-1:0][2*RB-1:0]     sq_radicand;
   logic [SIDE_A-1:0]              sq_side_in, sq_side_out;
   logic                           sq_valid;
   logic [LANES-1:0][RB-1:0]       sq_root;

   always_comb begin
      flat_a         = (s_ff == '0);
      spacelike_a    = m_ff[NW-1] || (m_ff == '0);
      r_mag          = r_ff[NW-1] ? -r_ff : r_ff;
      // The squared pair pt reaches twice the square of the largest sum,
      // so it needs every bit below the sign.
      sq_radicand[0] = {s_ff[2*MB+1:0], {(2*GUARD_BITS){1'b0}}};
      sq_radicand[1] = {2'b00, m_ff[2*MB-1:0], {(2*GUARD_BITS){1'b0}}};
      sq_radicand[2] = {{(2*GUARD_BITS){1'b0}}, r_mag[2*MB+1:0]};
      sq_side_in     = {nout_ff, nside_ff, nlong_ff, flat_a, spacelike_a};
   end

   lprm_sqrt_pipe #(
      .ROOT_BITS (RB),
      .LANES     (LANES),
      .SIDE_BITS (SIDE_A)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s3_valid_ff),
      .in_radicand (sq_radicand),
      .in_side     (sq_side_in),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side_out)
   );

   // ---------------------------------------------------------------------
   // Preparation stage: numerator signs and magnitudes, divisor per lane,
   // invariant saturation.
   logic signed [NW-1:0]         sq_nout, sq_nside, sq_nlong;
   logic                         sq_flat, sq_spacelike;
   logic                         pre_valid_ff;
   logic [LANES-1:0]             pre_neg_ff, pre_neg_in;
   logic [LANES-1:0][NB-1:0]     pre_mag_ff, pre_mag_in;
   logic [LANES-1:0][RB-1:0]     pre_den_ff, pre_den_in;
   logic                         pre_flat_ff, pre_spacelike_ff;
   logic                         pre_qisat_ff, pre_qisat_in;
   logic [MB-2:0]                pre_qi_ff, pre_qi_in;

   assign {sq_nout, sq_nside, sq_nlong, sq_flat, sq_spacelike} = sq_side_out;

   always_comb begin
      logic signed [NW-1:0] num [LANES];
      logic signed [NW-1:0] pos;
      num[0] = sq_nout;
      num[1] = sq_nside;
      num[2] = sq_nlong;
      for (int l = 0; l < LANES; l++) begin
         pos           = num[l][NW-1] ? -num[l] : num[l];
         pre_neg_in[l] = num[l][NW-1];
         pre_mag_in[l] = pos[NB-1:0];
      end
      // Out and side share the pair pt root; long uses the transverse mass.
      pre_den_in[0] = sq_root[0];
      pre_den_in[1] = sq_root[0];
      pre_den_in[2] = sq_root[1];
      pre_qisat_in  = |sq_root[2][RB-1:MB-1];
      pre_qi_in     = pre_qisat_in ? '1 : sq_root[2][MB-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (advance) begin
         pre_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_neg_ff       <= pre_neg_in;
         pre_mag_ff       <= pre_mag_in;
         pre_den_ff       <= pre_den_in;
         pre_flat_ff      <= sq_flat;
         pre_spacelike_ff <= sq_spacelike;
         pre_qisat_ff     <= pre_qisat_in;
         pre_qi_ff        <= pre_qi_in;
      end
   end

   // ---------------------------------------------------------------------
   // Division of the scaled numerators. The head of the dividend is
   // checked against the divisor first: when it is not smaller, the
   // quotient cannot fit in a momentum word and the lane saturates.
   logic [LANES-1:0]             div_ovf;
   logic [LANES-1:0][RB-1:0]     div_rem;
   logic [LANES-1:0][MB-1:0]     div_low;
   logic [SIDE_B-1:0]            div_side_in, div_side_out;
   logic                         div_valid;
   logic [LANES-1:0][MB-1:0]     div_quot;

   always_comb begin
      logic [XB-1:0] x_word;
      logic [HB-1:0] head;
      for (int l = 0; l < LANES; l++) begin
         x_word     = {pre_mag_ff[l], {GUARD_BITS{1'b0}}};
         head       = x_word[XB-1:MB];
         div_ovf[l] = (head >= HB'(pre_den_ff[l]));
         div_rem[l] = head[RB-1:0];
         div_low[l] = x_word[MB-1:0];
      end
      div_side_in = {pre_flat_ff, pre_spacelike_ff, pre_neg_ff, div_ovf,
                     pre_qisat_ff, pre_qi_ff};
   end

   lprm_div_pipe #(
      .DEN_BITS  (RB),
      .QUO_BITS  (MB),
      .LANES     (LANES),
      .SIDE_BITS (SIDE_B)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pre_valid_ff),
      .in_rem    (div_rem),
      .in_low    (div_low),
      .in_den    (pre_den_ff),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side_out)
   );

   // ---------------------------------------------------------------------
   // Output stage: saturate, restore signs, mask degenerate lanes and
   // pick the status code.
   logic             dv_flat, dv_spacelike, dv_qisat;
   logic [LANES-1:0] dv_neg, dv_ovf;
   logic [MB-2:0]    dv_qi;
   rsp_type          rsp_ff, rsp_in;

   assign {dv_flat, dv_spacelike, dv_neg, dv_ovf, dv_qisat, dv_qi} = div_side_out;

   always_comb begin
      logic [MB-1:0]    lim;
      logic [MB-1:0]    mag;
      logic [MB-1:0]    word [LANES];
      logic [LANES-1:0] lane_sat;
      for (int l = 0; l < LANES; l++) begin
         // A negative result may reach one step further than a positive.
         lim         = {1'b0, {(MB-1){1'b1}}} + MB'(dv_neg[l]);
         lane_sat[l] = dv_ovf[l] || (div_quot[l] > lim);
         mag         = lane_sat[l] ? lim : div_quot[l];
         word[l]     = dv_neg[l] ? -mag : mag;
      end
      rsp_in.q_out       = dv_flat ? '0 : 32'(word[0]);
      rsp_in.q_side      = dv_flat ? '0 : 32'(word[1]);
      rsp_in.q_long      = dv_spacelike ? '0 : 32'(word[2]);
      rsp_in.q_invariant = 31'(dv_qi);
      if (dv_flat) begin
         rsp_in.status = STATUS_FLAT;
      end else if (dv_spacelike) begin
         rsp_in.status = STATUS_SPACELIKE;
      end else if ((|lane_sat) || dv_qisat) begin
         rsp_in.status = STATUS_SATURATED;
      end else begin
         rsp_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the LCMS pair relative momentum block.
// Drives random and directed pairs under all pair modes with random stalls and
// checks every response word against a bit-exact predictor. Depends on lprm_pkg.
`timescale 1ns / 1ps

import lprm_pkg::*;

// Predicts the response word for every accepted pair and checks responses in order.
class momentum_scoreboard;
   rsp_type    pending[$];
   logic [1:0] mode;
   int         mismatches;

   function new();
      mode = MODE_NORMAL;
      mismatches = 0;
   endfunction

   // Bit-serial floor square root of a wide unsigned value.
   function logic [63:0] root(input logic [159:0] x);
      logic [63:0]  r;
      logic [159:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = {96'd0, r | (64'd1 << b)};
         if (c * c <= x) begin
            r = c[63:0];
         end
      end
      return r;
   endfunction

   // Divides num * 2^30 by den, truncating toward zero, and saturates to 32 bits.
   function logic [31:0] scaled(input logic signed [159:0] num, input logic [63:0] den,
                                inout bit sat);
      logic [159:0] m;
      logic [159:0] q;
      logic [159:0] lim;
      bit           neg;
      neg = num < 0;
      m = neg ? -num : num;
      q = (m << GUARD_BITS) / {96'd0, den};
      lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
      if (q > lim) begin
         sat = 1;
         q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function rsp_type lcms_q(input req_type w);
      logic signed [159:0] ax, ay, az, ae, bx, by, bz, be;
      logic signed [159:0] px, py, pz, e, dx, dy, dz, de, s, m, r;
      logic [159:0]        rm;
      logic [63:0]         qi;
      rsp_type             o;
      bit                  sat, flat, spacelike;
      ax = w.p1_x; ay = w.p1_y; az = w.p1_z;
      bx = w.p2_x; by = w.p2_y; bz = w.p2_z;
      ae = $signed({129'd0, w.p1_energy});
      be = $signed({129'd0, w.p2_energy});
      sat = 0;
      o = '0;
      // Any nonzero mode mirrors particle two in the transverse plane; the
      // upper mode bit also mirrors it along the beam.
      if (mode != MODE_NORMAL) begin
         bx = -bx;
         by = -by;
      end
      if (mode[MODE_Z_MIRROR_BIT]) begin
         bz = -bz;
      end
      px = ax + bx; py = ay + by; pz = az + bz; e = ae + be;
      dx = ax - bx; dy = ay - by; dz = az - bz; de = ae - be;
      s = px * px + py * py;
      flat = s == 0;
      if (!flat) begin
         o.q_out  = scaled(dx * px + dy * py, root(s << (2 * GUARD_BITS)), sat);
         o.q_side = scaled(dy * px - dx * py, root(s << (2 * GUARD_BITS)), sat);
      end
      m = e * e - pz * pz;
      spacelike = m <= 0;
      if (!spacelike) begin
         o.q_long = scaled(e * dz - pz * de, root(m << (2 * GUARD_BITS)), sat);
      end
      r = dx * dx + dy * dy + dz * dz - de * de;
      rm = r < 0 ? -r : r;
      qi = root(rm);
      if (qi > 64'h7FFF_FFFF) begin
         qi = 64'h7FFF_FFFF;
         sat = 1;
      end
      o.q_invariant = qi[30:0];
      if (flat) o.status = STATUS_FLAT;
      else if (spacelike) o.status = STATUS_SPACELIKE;
      else if (sat) o.status = STATUS_SATURATED;
      else o.status = STATUS_OK;
      return o;
   endfunction

   function void note_pair(input req_type w);
      pending.push_back(lcms_q(w));
   endfunction

   function void fail(input string what, input rsp_type exp_w, input rsp_type got_w);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_w, got_w);
      end
   endfunction

   function void check_word(input rsp_type got_w);
      rsp_type exp_w;
      if (pending.size() == 0) begin
         fail("unexpected word", '0, got_w);
         return;
      end
      exp_w = pending.pop_front();
      if (got_w.q_out !== exp_w.q_out) fail("q_out", exp_w, got_w);
      if (got_w.q_side !== exp_w.q_side) fail("q_side", exp_w, got_w);
      if (got_w.q_long !== exp_w.q_long) fail("q_long", exp_w, got_w);
      if (got_w.q_invariant !== exp_w.q_invariant) fail("q_invariant", exp_w, got_w);
      if (got_w.status !== exp_w.status) fail("status", exp_w, got_w);
   endfunction
endclass

module testbench;

   localparam int LATENCY   = 2 * 32 + 36;
   localparam int WATCHDOG  = 20000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 0;
   logic [1:0] csr_write_data = '0;

   momentum_scoreboard board = new();
   bit  calm;           // when set, neither side idles
   int  stall_left;
   int  quiet_cycles;

   lcms_pair_relative_momentum u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // Both channels are sampled at the rising edge, before any of the
   // nonblocking updates of that edge take effect, so the values seen here
   // are exactly the ones the block acts on.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_pair(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word(rsp_data);
      end
   end

   // The receiver draws a stall length for every word it takes. The stall
   // line is only ever assigned once per edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = calm ? 0 : $urandom_range(0, 8);
         rsp_stall <= stall_left != 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= stall_left != 0;
      end
   end

   // Watchdog: a healthy run never goes long without moving a word on
   // either channel, the longest legal lull being a drain plus the settle
   // time before a mode write.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL lcms_pair_relative_momentum");
            $finish;
         end
      end
   end

   // Sends one pair: an optional idle gap, then hold valid until the word
   // is taken. Valid stays high straight into the next word when no gap
   // is drawn, so it never gets two assignments at one edge.
   task automatic send_pair(input req_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Waits until every expected word has come back, then lets the pipeline
   // settle for its full latency.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] value);
      drain();
      csr_write_enable <= 1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      board.mode = value;
   endtask

   function automatic logic signed [31:0] small_mom();
      return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
   endfunction

   function automatic logic [30:0] mom_abs(input logic signed [31:0] v);
      return 31'(v < 0 ? -v : v);
   endfunction

   // Mostly physical particles with energy above the momentum magnitude,
   // so the pair is timelike and reaches the full out/side/long path. The
   // rest are full-range noise, back-to-back pairs with no transverse
   // momentum, and pairs whose energy is too small.
   function automatic req_type random_pair();
      req_type w;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         w.p1_x = $urandom; w.p1_y = $urandom; w.p1_z = $urandom;
         w.p2_x = $urandom; w.p2_y = $urandom; w.p2_z = $urandom;
         w.p1_energy = 31'($urandom); w.p2_energy = 31'($urandom);
      end else begin
         w.p1_x = small_mom(); w.p1_y = small_mom(); w.p1_z = small_mom();
         w.p2_x = small_mom(); w.p2_y = small_mom(); w.p2_z = small_mom();
         if (pick < 32) begin
            // Cancel the pair transverse momentum for the current mode.
            if (board.mode == MODE_NORMAL) begin
               w.p2_x = -w.p1_x;
               w.p2_y = -w.p1_y;
            end else begin
               w.p2_x = w.p1_x;
               w.p2_y = w.p1_y;
            end
         end
         w.p1_energy = 31'(mom_abs(w.p1_x) + mom_abs(w.p1_y) + mom_abs(w.p1_z)
                           + $urandom_range(0, 1 << 19));
         w.p2_energy = 31'(mom_abs(w.p2_x) + mom_abs(w.p2_y) + mom_abs(w.p2_z)
                           + $urandom_range(0, 1 << 19));
         if (pick >= 92) begin
            w.p1_energy = 31'($urandom_range(0, 1 << 12));
            w.p2_energy = 31'($urandom_range(0, 1 << 12));
         end
      end
      return w;
   endfunction

   task automatic directed_pairs();
      req_type w;
      // All zero: no pair pt and a non-timelike pair at once.
      w = '0;
      send_pair(w);
      // Every field at its most negative or largest value.
      w.p1_x = 32'sh8000_0000; w.p1_y = 32'sh8000_0000; w.p1_z = 32'sh8000_0000;
      w.p2_x = 32'sh8000_0000; w.p2_y = 32'sh8000_0000; w.p2_z = 32'sh8000_0000;
      w.p1_energy = '1; w.p2_energy = '1;
      send_pair(w);
      w.p1_x = 32'sh7FFF_FFFF; w.p1_y = 32'sh7FFF_FFFF; w.p1_z = 32'sh7FFF_FFFF;
      w.p2_x = 32'sh7FFF_FFFF; w.p2_y = 32'sh8000_0000; w.p2_z = 32'sh7FFF_FFFF;
      send_pair(w);
      w.p1_energy = 0; w.p2_energy = '1;
      send_pair(w);
      // Opposite extremes, which drive the invariant into saturation.
      w.p1_x = 32'sh7FFF_FFFF; w.p1_y = 0; w.p1_z = 32'sh7FFF_FFFF;
      w.p2_x = 32'sh8000_0000; w.p2_y = 32'sh7FFF_FFFF; w.p2_z = 32'sh8000_0000;
      w.p1_energy = 0; w.p2_energy = 0;
      send_pair(w);
      // Identical particles give zero relative momentum.
      w.p1_x = 32'sd65536; w.p1_y = 32'sd131072; w.p1_z = -32'sd65536;
      w.p1_energy = 31'd300000;
      w.p2_x = w.p1_x; w.p2_y = w.p1_y; w.p2_z = w.p1_z; w.p2_energy = w.p1_energy;
      send_pair(w);
      // Pair pt along x only, then along y only.
      w = '0;
      w.p1_x = 32'sd65536; w.p1_energy = 31'd200000; w.p2_energy = 31'd100000;
      send_pair(w);
      w = '0;
      w.p1_y = -32'sd65536; w.p2_z = 32'sd40000; w.p1_energy = 31'd200000;
      w.p2_energy = 31'd100000;
      send_pair(w);
      // Lightlike pair: energy equal to the beam momentum.
      w = '0;
      w.p1_x = 32'sd1000; w.p1_z = 32'sd65536; w.p1_energy = 31'd65536;
      send_pair(w);
      // Tiny energies with moderate momenta: spacelike pair.
      w.p1_x = 32'sd70000; w.p1_y = 32'sd5; w.p1_z = 32'sd90000; w.p1_energy = 31'd1;
      w.p2_x = -32'sd3; w.p2_y = 32'sd80000; w.p2_z = -32'sd20000; w.p2_energy = 31'd2;
      send_pair(w);
      // Huge energy difference next to tiny momenta.
      w = '0;
      w.p1_x = 32'sd1; w.p1_energy = 31'h7FFF_FFFF; w.p2_energy = 31'd1;
      send_pair(w);
   endtask

   initial begin
      logic [1:0] modes [5];
      modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
      calm = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int p = 0; p < 5; p++) begin
         write_mode(modes[p]);
         directed_pairs();
         for (int i = 0; i < 240; i++) begin
            calm = (i % 80) < 15;
            // The sender holds off once per phase until the pipeline empties.
            if (i == 120) begin
               drain();
            end
            send_pair(random_pair());
         end
      end
      drain();
      if (board.mismatches == 0) begin
         $display("PASS lcms_pair_relative_momentum");
      end else begin
         $display("FAIL lcms_pair_relative_momentum");
      end
      $finish;
   end

endmodule
